// ===== hdl/dfq_pkg.sv =====
package dfq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int OP_W      = 3;
  localparam int KEY_IO_W  = 32;
  localparam int OCC_W     = 5;
  localparam int OCC_LSB   = KEY_IO_W;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 2;
  localparam int HIT_BIT   = 0;
  localparam int REF_BIT   = 1;

  localparam logic [OP_W-1:0] OP_ENQ          = 3'd0;
  localparam logic [OP_W-1:0] OP_ENQ_DISTINCT = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQ          = 3'd2;
  localparam logic [OP_W-1:0] OP_CONTAINS     = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK         = 3'd4;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [KEY_WIDTH-1:0] key_t;

  function automatic idx_t wrap_inc(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

// ===== hdl/distinct_fifo_queue.sv =====
// channel  dir  tvalid/tready         tdata                          tuser
// s        in   s_tvalid / s_tready   [31:0] key                     [2:0] opcode
// m        out  m_tvalid / m_tready   [31:0] key_out, [36:32] occ    [0] hit, [1] refused
//
// One request at a time. Enqueue and spare opcodes go straight to finish;
// dequeue and peek read the oldest entry in the scan state; contains and
// distinct enqueue make one ring read per entry checked (at least one, at
// most max(1, occupancy), stops on a match), through the single read port.
// Reset (rst, sync) empties the queue; ring contents are not cleared.
// A new request is taken while a result waits; the request completes once
// the output register is free.
module distinct_fifo_queue import dfq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] key
  input  logic [OP_W-1:0]      s_tuser,   // [2:0] opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] key_out, [36:32] occupancy
  output logic [M_TUSER_W-1:0] m_tuser    // [0] hit, [1] refused
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [OP_W-1:0]  op;
  key_t             key;
  key_t             word;
  logic             found;
  idx_t             oldest;
  idx_t             next_free;
  idx_t             scan_idx;
  cnt_t             count;
  cnt_t             checked;

  logic [KEY_IO_W-1:0] out_key;
  logic                out_hit;
  logic                out_refused;
  logic [OCC_W-1:0]    out_occ;

  logic   ram_we;
  idx_t   ram_raddr;
  key_t   ram_rdata;

  logic   accept;
  logic   finish_go;
  logic   do_append;
  logic   full;
  logic   is_search;
  logic   match;

  logic [KEY_IO_W-1:0] res_key;
  logic                res_hit;
  logic                res_refused;
  cnt_t                count_next;
  idx_t                oldest_next;
  idx_t                next_free_next;

  dfq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_free),
    .wdata (key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ram_raddr = (state == ST_IDLE) ? oldest : scan_idx;
  assign finish_go = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign full      = (count == CNT_W'(DEPTH));
  assign do_append = (op == OP_ENQ) || ((op == OP_ENQ_DISTINCT) && !found);
  assign ram_we    = finish_go && do_append && !full;
  assign is_search = (op == OP_ENQ_DISTINCT) || (op == OP_CONTAINS);
  assign match     = (checked < count) && (ram_rdata == key);

  always_comb begin
    res_key        = '0;
    res_hit        = 1'b0;
    res_refused    = 1'b0;
    count_next     = count;
    oldest_next    = oldest;
    next_free_next = next_free;
    case (op) inside
      OP_ENQ, OP_ENQ_DISTINCT: begin
        if (op == OP_ENQ_DISTINCT && found) begin
          res_hit = 1'b1;
        end else if (full) begin
          res_refused = 1'b1;
        end else begin
          count_next     = count + CNT_W'(1);
          next_free_next = wrap_inc(next_free);
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (count != '0) begin
          res_key = KEY_IO_W'(word);
          res_hit = 1'b1;
          if (op == OP_DEQ) begin
            count_next  = count - CNT_W'(1);
            oldest_next = wrap_inc(oldest);
          end
        end
      end
      OP_CONTAINS: begin
        res_hit = found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      oldest    <= '0;
      next_free <= '0;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (finish_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op       <= s_tuser;
            key      <= s_tdata[KEY_WIDTH-1:0];
            found    <= 1'b0;
            checked  <= '0;
            scan_idx <= wrap_inc(oldest);
            if (s_tuser == OP_ENQ || s_tuser > OP_PEEK) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!is_search) begin
            word  <= ram_rdata;
            state <= ST_FINISH;
          end else begin
            found    <= found || match;
            checked  <= checked + CNT_W'(1);
            scan_idx <= wrap_inc(scan_idx);
            if (match || (checked + CNT_W'(1) >= count)) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_key     <= res_key;
            out_hit     <= res_hit;
            out_refused <= res_refused;
            out_occ     <= OCC_W'(count_next);
            count       <= count_next;
            oldest      <= oldest_next;
            next_free   <= next_free_next;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {(M_TDATA_W - OCC_W - KEY_IO_W)'(0), out_occ, out_key};
  assign m_tuser = {out_refused, out_hit};

endmodule

// ===== hdl/dfq_ram.sv =====
module dfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [ADDR_W-1:0]       raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dfq_checker.sv =====
module dfq_checker import dfq_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  logic [OCC_W-1:0]    occ;
  logic [KEY_IO_W-1:0] kout;

  assign occ  = m_tdata[OCC_LSB +: OCC_W];
  assign kout = m_tdata[KEY_IO_W-1:0];

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_hit_refused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[HIT_BIT] && m_tuser[REF_BIT]))
    else $error("hit and refused together");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[REF_BIT] |-> occ == OCC_W'(DEPTH) && kout == '0)
    else $error("refused while not full");

  a_key_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kout != '0 |-> m_tuser[HIT_BIT])
    else $error("key_out without hit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind distinct_fifo_queue dfq_checker u_dfq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
